/* rtl/core/ksp_pkg.sv */
package ksp_pkg;

	// Pool geometry. The slot index width of the command channel follows from it.
	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	// Widths of the channel fields.
	localparam int ACTION_W   = 3;
	localparam int KEY_W      = 64;
	localparam int PAYLOAD_W  = 64;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_LOOKUP = 3'd2,
		ACT_READ   = 3'd3,
		ACT_NEXT   = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic cap_match;
		logic cap_slot;
		logic commit;
	} ksp_ctl_t;

	// Index of the single set bit of a one-hot vector, zero when none is set.
	function automatic logic [SLOT_W-1:0] onehot_enc(input logic [SLOT_COUNT-1:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (v[i]) begin
				r = r | SLOT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/ksp_cmd_if.sv */
interface ksp_cmd_if import ksp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [KEY_W-1:0]      key;
	logic [PAYLOAD_W-1:0]  payload;
	logic [SLOT_W-1:0]     slot_index;

	modport source (output valid, action, key, payload, slot_index, input ready);
	modport sink (input valid, action, key, payload, slot_index, output ready);
endinterface

/* rtl/core/ksp_rsp_if.sv */
interface ksp_rsp_if import ksp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [KEY_W-1:0]      key_out;
	logic [PAYLOAD_W-1:0]  payload_out;

	modport source (output valid, status, slot_out, key_out, payload_out, input ready);
	modport sink (input valid, status, slot_out, key_out, payload_out, output ready);
endinterface

/* rtl/core/ksp_ram.sv */
module ksp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/ksp_ctrl.sv */
module ksp_ctrl import ksp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ksp_ctl_t ctl
);

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_MATCH;
				end
			end
			S_MATCH: begin
				ctl.cap_match = 1'b1;
				state_d       = S_DECIDE;
			end
			S_DECIDE: begin
				ctl.cap_slot = 1'b1;
				state_d      = S_COMMIT;
			end
			S_COMMIT: begin
				// The table is only changed once the result has a place to go.
				if (!rsp_valid_q || rsp_ready) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/core/ksp_dp.sv */
module ksp_dp import ksp_pkg::*; #(
	parameter int KEY_BITS     = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ksp_ctl_t              ctl,
	input  logic [ACTION_W-1:0]   action,
	input  logic [KEY_W-1:0]      key,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [SLOT_W-1:0]     slot_index,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot_out,
	output logic [KEY_W-1:0]      key_out,
	output logic [PAYLOAD_W-1:0]  payload_out
);

	// Request registers.
	logic [ACTION_W-1:0]     action_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [SLOT_W-1:0]       idx_q;

	// Slot state held in flip-flops: match keys, used bits, link valid bits, list head.
	logic [KEY_BITS-1:0]     cell_key_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   used_q;
	logic [SLOT_COUNT-1:0]   link_vld_q;
	logic [CNT_W-1:0]        free_head_q;

	// Match and search vectors.
	logic [SLOT_COUNT-1:0]   hit_q;
	logic [SLOT_COUNT-1:0]   occ_q;
	logic [SLOT_COUNT-1:0]   below;
	logic [SLOT_COUNT-1:0]   hit_d;

	// Decision registers.
	logic [CNT_W-1:0]        slot_q, slot_d;
	logic                    found_q, found_d;
	logic                    full_q;
	logic                    used_at_q;
	logic                    link_vld_at_q;
	logic [CNT_W-1:0]        link_dflt_q;
	logic [SLOT_COUNT-1:0]   low_bit;
	logic                    hit_any;
	logic [SLOT_W-1:0]       hit_idx;

	// Output register.
	logic [STATUS_W-1:0]     status_q;
	logic [SLOT_OUT_W-1:0]   slot_out_q;
	logic [KEY_W-1:0]        key_out_q;
	logic [PAYLOAD_W-1:0]    payload_out_q;

	// Memory ports.
	logic                    new_ins, overwrite, remove_hit;
	logic [SLOT_W-1:0]       slot_addr;
	logic [KEY_BITS-1:0]     key_rd;
	logic [PAYLOAD_BITS-1:0] pay_rd;
	logic [CNT_W-1:0]        link_rd;
	logic [CNT_W-1:0]        link_next;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			action_q  <= action;
			key_q     <= key[KEY_BITS-1:0];
			payload_q <= payload[PAYLOAD_BITS-1:0];
			idx_q     <= slot_index;
		end
	end

	// Parallel key compare over the used slots, and the occupied slots at or after the index.
	assign below = (SLOT_COUNT'(1) << idx_q) - SLOT_COUNT'(1);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			hit_d[i] = used_q[i] && (cell_key_q[i] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_match) begin
			hit_q <= hit_d;
			occ_q <= used_q & ~below;
		end
	end

	// Keys are unique among used slots, so the hit vector is one-hot or empty.
	assign hit_any = |hit_q;
	assign hit_idx = onehot_enc(hit_q);
	assign low_bit = occ_q & (~occ_q + SLOT_COUNT'(1));

	always_comb begin
		slot_d  = '0;
		found_d = 1'b0;
		case (action_q)
			ACT_INSERT: begin
				found_d = hit_any;
				slot_d  = hit_any ? CNT_W'(hit_idx) : free_head_q;
			end
			ACT_REMOVE, ACT_LOOKUP: begin
				found_d = hit_any;
				slot_d  = CNT_W'(hit_idx);
			end
			ACT_READ: begin
				found_d = CNT_W'(idx_q) < CNT_W'(SLOT_COUNT);
				slot_d  = CNT_W'(idx_q);
			end
			ACT_NEXT: begin
				found_d = |occ_q;
				slot_d  = CNT_W'(onehot_enc(low_bit));
			end
			default: begin
				found_d = 1'b0;
				slot_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_slot) begin
			slot_q        <= slot_d;
			found_q       <= found_d;
			full_q        <= free_head_q >= CNT_W'(SLOT_COUNT);
			used_at_q     <= used_q[slot_d[SLOT_W-1:0]];
			link_vld_at_q <= link_vld_q[free_head_q[SLOT_W-1:0]];
			link_dflt_q   <= free_head_q + CNT_W'(1);
		end
	end

	// Write-back decisions, valid in the commit cycle.
	assign new_ins    = (action_q == ACT_INSERT) && !found_q && !full_q;
	assign overwrite  = (action_q == ACT_INSERT) && found_q;
	assign remove_hit = (action_q == ACT_REMOVE) && found_q;
	assign slot_addr  = ctl.commit ? slot_q[SLOT_W-1:0] : slot_d[SLOT_W-1:0];
	// A link never written reads as its default value, the next slot number.
	assign link_next  = link_vld_at_q ? link_rd : link_dflt_q;

	ksp_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOT_COUNT)) u_key_ram (
		.clk     (clk),
		.wr_en   (ctl.commit && new_ins),
		.wr_addr (slot_addr),
		.wr_data (key_q),
		.rd_en   (ctl.cap_slot),
		.rd_addr (slot_addr),
		.rd_data (key_rd)
	);

	ksp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOT_COUNT)) u_pay_ram (
		.clk     (clk),
		.wr_en   (ctl.commit && (new_ins || overwrite)),
		.wr_addr (slot_addr),
		.wr_data (payload_q),
		.rd_en   (ctl.cap_slot),
		.rd_addr (slot_addr),
		.rd_data (pay_rd)
	);

	ksp_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_link_ram (
		.clk     (clk),
		.wr_en   (ctl.commit && remove_hit),
		.wr_addr (slot_addr),
		.wr_data (free_head_q),
		.rd_en   (ctl.cap_slot),
		.rd_addr (free_head_q[SLOT_W-1:0]),
		.rd_data (link_rd)
	);

	always_ff @(posedge clk) begin
		if (ctl.commit && new_ins) begin
			cell_key_q[slot_q[SLOT_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			link_vld_q  <= '0;
			free_head_q <= '0;
		end else if (ctl.commit) begin
			if (new_ins) begin
				used_q[slot_q[SLOT_W-1:0]] <= 1'b1;
				free_head_q                <= link_next;
			end else if (remove_hit) begin
				used_q[slot_q[SLOT_W-1:0]]     <= 1'b0;
				link_vld_q[slot_q[SLOT_W-1:0]] <= 1'b1;
				free_head_q                    <= slot_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q      <= ST_MISS;
			slot_out_q    <= '0;
			key_out_q     <= '0;
			payload_out_q <= '0;
			case (action_q)
				ACT_INSERT: begin
					if (found_q || !full_q) begin
						status_q      <= ST_OK;
						slot_out_q    <= SLOT_OUT_W'(slot_q);
						key_out_q     <= KEY_W'(key_q);
						payload_out_q <= PAYLOAD_W'(payload_q);
					end else begin
						status_q <= ST_FULL;
					end
				end
				ACT_REMOVE: begin
					if (found_q) begin
						status_q      <= ST_OK;
						slot_out_q    <= SLOT_OUT_W'(slot_q);
						payload_out_q <= PAYLOAD_W'(pay_rd);
					end
				end
				ACT_LOOKUP: begin
					if (found_q) begin
						status_q      <= ST_OK;
						slot_out_q    <= SLOT_OUT_W'(slot_q);
						key_out_q     <= KEY_W'(key_q);
						payload_out_q <= PAYLOAD_W'(pay_rd);
					end
				end
				ACT_READ: begin
					slot_out_q <= SLOT_OUT_W'(slot_q);
					if (found_q) begin
						status_q      <= ST_OK;
						key_out_q     <= used_at_q ? KEY_W'(key_rd) : '0;
						payload_out_q <= PAYLOAD_W'(pay_rd);
					end
				end
				ACT_NEXT: begin
					if (found_q) begin
						status_q      <= ST_OK;
						slot_out_q    <= SLOT_OUT_W'(slot_q);
						key_out_q     <= KEY_W'(key_rd);
						payload_out_q <= PAYLOAD_W'(pay_rd);
					end else begin
						slot_out_q <= SLOT_OUT_W'(SLOT_COUNT);
					end
				end
				default: begin
					status_q <= ST_MISS;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign slot_out    = slot_out_q;
	assign key_out     = key_out_q;
	assign payload_out = payload_out_q;

endmodule

/* rtl/core/keyed_slot_pool_unit.sv */
// Channel  Dir  Fields                                   Accepted when
// -------  ---  ---------------------------------------  -------------------------
// cmd      in   action, key, payload, slot_index         cmd.valid && cmd.ready
// rsp      out  status, slot_out, key_out, payload_out   rsp.valid && rsp.ready
//
// Every item goes through four steps: accept, key match, slot decision with the memory
// reads, and commit. The registered reads of the key, data and link memories set this.
// Reset clears the used bits, the link valid bits and the free-list head at once;
// no clearing pass runs. A finished result waits in the output register while the
// next item is taken in; only the commit step stalls while that register is still full.

module keyed_slot_pool_unit import ksp_pkg::*; #(
	parameter int KEY_BITS     = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ksp_cmd_if.sink     cmd,
	ksp_rsp_if.source   rsp
);

	// The controller sequences each item; the datapath holds the slot table.
	ksp_ctl_t ctl;

	ksp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	// Match keys live in flip-flops so that a lookup compares all slots at once.
	// Keys and data words for reading out live in memories; a free slot may keep an old
	// key in memory, but its key reads as zero through the used bit.
	ksp_dp #(
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.action      (cmd.action),
		.key         (cmd.key),
		.payload     (cmd.payload),
		.slot_index  (cmd.slot_index),
		.status      (rsp.status),
		.slot_out    (rsp.slot_out),
		.key_out     (rsp.key_out),
		.payload_out (rsp.payload_out)
	);

endmodule
